// File: rtl/ifa_pkg.sv
`timescale 1ns / 1ps

package ifa_pkg;

  localparam logic [2:0] CMD_CHAR = 3'd0;
  localparam logic [2:0] CMD_SDEC = 3'd1;
  localparam logic [2:0] CMD_UDEC = 3'd2;
  localparam logic [2:0] CMD_HEXL = 3'd3;
  localparam logic [2:0] CMD_HEXU = 3'd4;
  localparam logic [2:0] CMD_PTR  = 3'd5;

  localparam logic [1:0] KIND_LIT = 2'd0;
  localparam logic [1:0] KIND_DEC = 2'd1;
  localparam logic [1:0] KIND_HEX = 2'd2;
  localparam logic [1:0] KIND_PTR = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_UPA   = 8'h41;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } rsp_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic        neg;
    logic        upper;
    logic [63:0] operand;
  } ent_t;

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    begin
      base = upper ? CH_UPA : CH_LOWA;
      if (nib < 4'd10) begin
        digit_char = CH_ZERO + {4'd0, nib};
      end else begin
        digit_char = base + {4'd0, nib} - 8'd10;
      end
    end
  endfunction

endpackage

// File: rtl/integer_to_ascii_formatter_unit.sv
`timescale 1ns / 1ps

// Integer-to-ASCII formatter.
// Request channel (req_valid / req_stall / req): one request carries a kind
// (cmd) and a 64-bit value; it is taken at an edge with req_valid high and
// req_stall low. Kinds 6 and 7 are taken and produce nothing.
// Response channel (rsp_valid / rsp_stall / rsp): one character per
// response, last_char set on the final character of a request.
// A front classifier writes requests into a two-entry queue; the back end
// pulls one request at a time and formats it.
// Steps per request in the back end: it pulls the request, then
//   literal: one character; hex: 8 digit positions; pointer: '0', 'x' and
//   16 digit positions; decimal: 32 shift-add steps of the BCD converter,
//   then an optional '-' and 10 digit positions. Leading zeros are skipped.
// The output register shows each character the cycle after it is emitted.
// The queue lets two more requests be taken while one is formatted.
// Reset empties the queue, returns the back end to idle and drops any
// pending response. A stalled response holds; the back end waits on it.
module integer_to_ascii_formatter_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ifa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ifa_pkg::rsp_t rsp
);

  ifa_pkg::ent_t wr_ent;
  ifa_pkg::ent_t rd_ent;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  assign req_stall = q_full;

  ifa_front u_front (
    .req       (req),
    .req_valid (req_valid),
    .q_full    (q_full),
    .push      (push),
    .ent       (wr_ent)
  );

  ifa_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_ent (wr_ent),
    .pop    (pop),
    .rd_ent (rd_ent),
    .full   (q_full),
    .empty  (q_empty)
  );

  ifa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_ent     (rd_ent),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: rtl/ifa_front.sv
`timescale 1ns / 1ps

module ifa_front (
  input  ifa_pkg::req_t req,
  input  logic          req_valid,
  input  logic          q_full,
  output logic          push,
  output ifa_pkg::ent_t ent
);

  logic [31:0] low32;
  logic        known;

  assign low32 = req.value[31:0];

  always_comb begin
    known       = 1'b1;
    ent.kind    = ifa_pkg::KIND_LIT;
    ent.neg     = 1'b0;
    ent.upper   = 1'b0;
    ent.operand = {32'd0, low32};
    case (req.cmd)
      ifa_pkg::CMD_CHAR: begin
        ent.operand = {56'd0, req.value[7:0]};
      end
      ifa_pkg::CMD_SDEC: begin
        ent.kind    = ifa_pkg::KIND_DEC;
        ent.neg     = low32[31];
        ent.operand = {32'd0, low32[31] ? (~low32 + 32'd1) : low32};
      end
      ifa_pkg::CMD_UDEC: begin
        ent.kind = ifa_pkg::KIND_DEC;
      end
      ifa_pkg::CMD_HEXL: begin
        ent.kind = ifa_pkg::KIND_HEX;
      end
      ifa_pkg::CMD_HEXU: begin
        ent.kind  = ifa_pkg::KIND_HEX;
        ent.upper = 1'b1;
      end
      ifa_pkg::CMD_PTR: begin
        ent.kind    = ifa_pkg::KIND_PTR;
        ent.operand = req.value;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unknown kinds are taken and dropped
  assign push = req_valid && !q_full && known;

endmodule

// File: rtl/ifa_queue.sv
`timescale 1ns / 1ps

module ifa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ifa_pkg::ent_t wr_ent,
  input  logic          pop,
  output ifa_pkg::ent_t rd_ent,
  output logic          full,
  output logic          empty
);

  ifa_pkg::ent_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign rd_ent = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/ifa_back.sv
`timescale 1ns / 1ps

module ifa_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  ifa_pkg::ent_t q_ent,
  output logic          pop,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ifa_pkg::rsp_t rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LIT   = 3'd1;
  localparam logic [2:0] S_CONV  = 3'd2;
  localparam logic [2:0] S_PRE_A = 3'd3;
  localparam logic [2:0] S_PRE_B = 3'd4;
  localparam logic [2:0] S_DIG   = 3'd5;

  logic [2:0]  state;
  logic [1:0]  kind;
  logic        neg;
  logic        upper;
  logic [63:0] dig;
  logic [31:0] bin;
  logic [4:0]  step;
  logic [3:0]  idx;
  logic        started;

  logic        can_emit;
  logic        emit;
  logic [7:0]  emit_char;
  logic        emit_last;
  logic [3:0]  nib;
  logic        skip;
  logic [39:0] bcd_adj;

  assign can_emit = !rsp_valid || !rsp_stall;
  assign pop      = (state == S_IDLE) && !q_empty;
  assign nib      = dig[{idx, 2'b00} +: 4];
  assign skip     = (nib == 4'd0) && !started && (idx != 4'd0);

  // double-dabble correction on the ten BCD digits
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      bcd_adj[i*4 +: 4] = (dig[i*4 +: 4] >= 4'd5) ? (dig[i*4 +: 4] + 4'd3) : dig[i*4 +: 4];
    end
  end

  always_comb begin
    emit      = 1'b0;
    emit_char = ifa_pkg::CH_ZERO;
    emit_last = 1'b0;
    case (state)
      S_LIT: begin
        emit      = can_emit;
        emit_char = dig[7:0];
        emit_last = 1'b1;
      end
      S_PRE_A: begin
        emit      = can_emit;
        emit_char = (kind == ifa_pkg::KIND_PTR) ? ifa_pkg::CH_ZERO : ifa_pkg::CH_MINUS;
      end
      S_PRE_B: begin
        emit      = can_emit;
        emit_char = ifa_pkg::CH_X;
      end
      S_DIG: begin
        emit      = can_emit && !skip;
        emit_char = ifa_pkg::digit_char(nib, upper);
        emit_last = (idx == 4'd0);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            case (q_ent.kind)
              ifa_pkg::KIND_LIT: state <= S_LIT;
              ifa_pkg::KIND_DEC: state <= S_CONV;
              ifa_pkg::KIND_HEX: state <= S_DIG;
              default:           state <= S_PRE_A;
            endcase
          end
        end
        S_LIT: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        S_CONV: begin
          if (step == 5'd31) begin
            state <= neg ? S_PRE_A : S_DIG;
          end
        end
        S_PRE_A: begin
          if (emit) begin
            state <= (kind == ifa_pkg::KIND_PTR) ? S_PRE_B : S_DIG;
          end
        end
        S_PRE_B: begin
          if (emit) begin
            state <= S_DIG;
          end
        end
        S_DIG: begin
          if (emit && idx == 4'd0) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.char_code <= emit_char;
      rsp.last_char <= emit_last;
    end
    case (state)
      S_IDLE: begin
        kind    <= q_ent.kind;
        neg     <= q_ent.neg;
        upper   <= q_ent.upper;
        started <= 1'b0;
        step    <= 5'd0;
        bin     <= q_ent.operand[31:0];
        if (q_ent.kind == ifa_pkg::KIND_DEC) begin
          dig <= 64'd0;
          idx <= 4'd9;
        end else begin
          dig <= q_ent.operand;
          idx <= (q_ent.kind == ifa_pkg::KIND_PTR) ? 4'd15 : 4'd7;
        end
      end
      S_CONV: begin
        dig  <= {24'd0, bcd_adj[38:0], bin[31]};
        bin  <= {bin[30:0], 1'b0};
        step <= step + 5'd1;
      end
      S_DIG: begin
        if (skip) begin
          idx <= idx - 4'd1;
        end else if (emit) begin
          started <= 1'b1;
          if (idx != 4'd0) begin
            idx <= idx - 4'd1;
          end
        end
      end
      default: begin
        step <= step;
      end
    endcase
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  ifa_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  ifa_pkg::rsp_t rsp;

  ifa_pkg::rsp_t expected_chars[$];
  int   errors = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   rsp_stall_pct = 0;

  integer_to_ascii_formatter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_stall <= !rst && ($urandom_range(99) < rsp_stall_pct);
  end

  // character stream expected for one request, last flag on the final char
  function automatic void predict_chars(input ifa_pkg::req_t r);
    string         hex_lo;
    string         hex_up;
    logic [7:0]    chars[$];
    logic [7:0]    digits[$];
    logic [31:0]   low;
    logic [31:0]   mag;
    logic [63:0]   hv;
    logic          upper;
    ifa_pkg::rsp_t c;
    begin
      hex_lo = "0123456789abcdef";
      hex_up = "0123456789ABCDEF";
      low = r.value[31:0];
      upper = (r.cmd == ifa_pkg::CMD_HEXU);
      case (r.cmd)
        ifa_pkg::CMD_CHAR: chars.push_back(r.value[7:0]);
        ifa_pkg::CMD_SDEC, ifa_pkg::CMD_UDEC: begin
          mag = low;
          if (r.cmd == ifa_pkg::CMD_SDEC && low[31]) begin
            chars.push_back(ifa_pkg::CH_MINUS);
            mag = ~low + 32'd1;  // 0x80000000 stays as its own magnitude
          end
          do begin
            digits.push_front(ifa_pkg::CH_ZERO + 8'(mag % 32'd10));
            mag = mag / 32'd10;
          end while (mag != 32'd0);
        end
        ifa_pkg::CMD_HEXL, ifa_pkg::CMD_HEXU, ifa_pkg::CMD_PTR: begin
          hv = (r.cmd == ifa_pkg::CMD_PTR) ? r.value : {32'd0, low};
          if (r.cmd == ifa_pkg::CMD_PTR) begin
            chars.push_back(ifa_pkg::CH_ZERO);
            chars.push_back(ifa_pkg::CH_X);
          end
          do begin
            digits.push_front(upper ? hex_up[hv[3:0]] : hex_lo[hv[3:0]]);
            hv = hv >> 4;
          end while (hv != 64'd0);
        end
        default: ;
      endcase
      foreach (digits[i]) chars.push_back(digits[i]);
      foreach (chars[i]) begin
        c.char_code = chars[i];
        c.last_char = (i == chars.size() - 1);
        expected_chars.push_back(c);
      end
    end
  endfunction

  always @(posedge clk) begin
    ifa_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_chars.size() == 0) begin
        $error("char_code: expected none, got %h", rsp.char_code);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (rsp.char_code !== want.char_code) begin
          $error("char_code: expected %h, got %h", want.char_code, rsp.char_code);
          errors++;
        end
        if (rsp.last_char !== want.last_char) begin
          $error("last_char: expected %b, got %b", want.last_char, rsp.last_char);
          errors++;
        end
      end
    end
  end

  // leaves req_valid high after the accepting edge; a later idle gap or the end lowers it
  task automatic send_request(input logic [2:0] cmd, input logic [63:0] value);
    ifa_pkg::req_t r;
    begin
      r.cmd = cmd;
      r.value = value;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
        req_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req <= r;
      do @(posedge clk); while (req_stall);
      predict_chars(r);
    end
  endtask

  task automatic test_literal();
    send_request(ifa_pkg::CMD_CHAR, 64'h0);
    send_request(ifa_pkg::CMD_CHAR, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ifa_pkg::CMD_CHAR, 64'h1234_5678_9ABC_DE41);
  endtask

  task automatic test_signed_decimal();
    send_request(ifa_pkg::CMD_SDEC, 64'h0);
    send_request(ifa_pkg::CMD_SDEC, 64'h1);
    send_request(ifa_pkg::CMD_SDEC, 64'hFFFF_FFFF);
    send_request(ifa_pkg::CMD_SDEC, 64'h7FFF_FFFF);
    send_request(ifa_pkg::CMD_SDEC, 64'h8000_0000);
    send_request(ifa_pkg::CMD_SDEC, 64'hFFFF_FFF6);           // -10
    send_request(ifa_pkg::CMD_SDEC, 64'hDEAD_BEEF_C465_3600); // -1000000000, high bits set
  endtask

  task automatic test_unsigned_decimal();
    send_request(ifa_pkg::CMD_UDEC, 64'h0);
    send_request(ifa_pkg::CMD_UDEC, 64'hFFFF_FFFF);
    send_request(ifa_pkg::CMD_UDEC, 64'd1000000000);
    send_request(ifa_pkg::CMD_UDEC, 64'd10);
    send_request(ifa_pkg::CMD_UDEC, 64'hFFFF_FFFF_0000_0009);
  endtask

  task automatic test_hex();
    send_request(ifa_pkg::CMD_HEXL, 64'h0);
    send_request(ifa_pkg::CMD_HEXL, 64'hFFFF_FFFF_0000_000F);
    send_request(ifa_pkg::CMD_HEXU, 64'hABCD_EF01);
    send_request(ifa_pkg::CMD_HEXU, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_pointer();
    send_request(ifa_pkg::CMD_PTR, 64'h0);
    send_request(ifa_pkg::CMD_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ifa_pkg::CMD_PTR, 64'h8000_0000_0000_0000);
    send_request(ifa_pkg::CMD_PTR, 64'h1);
  endtask

  task automatic test_unused_kinds();
    send_request(3'd6, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(3'd7, 64'h1234);
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    logic [63:0] v;
    logic [2:0]  cmd;
    begin
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) begin
        v = {$urandom, $urandom};
        case ($urandom_range(3))
          0: v = v >> $urandom_range(63);
          1: v = v & 64'hFFFF;
          default: ;
        endcase
        if ($urandom_range(99) < 6) cmd = 3'($urandom_range(7, 6));
        else cmd = 3'($urandom_range(5, 0));
        send_request(cmd, v);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_literal();
    test_signed_decimal();
    test_unsigned_decimal();
    test_hex();
    test_pointer();
    test_unused_kinds();
    test_random(26, 0, 0);
    test_random(26, 47, 0);
    test_random(26, 0, 47);
    test_random(26, 38, 38);
    req_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
